>>> design/arlc_pkg.sv
// Package for the ack/retry link controller: field widths, operation and
// event codes, link modes and the item and result structs.
// No dependencies; every other design file imports it.
package arlc_pkg;

	localparam int SEQ_BITS       = 16;
	localparam int CHALLENGE_BITS = 32;
	localparam int RES_DEPTH      = 4;
	localparam int RES_PTR_BITS   = $clog2(RES_DEPTH);
	localparam int RES_CNT_BITS   = $clog2(RES_DEPTH + 1);

	localparam logic [SEQ_BITS-1:0] SEQ_ALL_ONES = {SEQ_BITS{1'b1}};

	// configuration register indexes and reset values
	localparam logic [1:0]  CFG_MAX_ATTEMPTS  = 2'd0;
	localparam logic [1:0]  CFG_ACK_TIMEOUT   = 2'd1;
	localparam logic [3:0]  MAX_ATTEMPTS_RST  = 4'd5;
	localparam logic [15:0] ACK_TIMEOUT_RST   = 16'd5000;

	// operations
	localparam logic [2:0] OP_OPEN   = 3'd0;
	localparam logic [2:0] OP_CLOSE  = 3'd1;
	localparam logic [2:0] OP_ACTION = 3'd2;
	localparam logic [2:0] OP_PACKET = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;

	// packet types
	localparam logic [1:0] PT_CONNECT = 2'd0;
	localparam logic [1:0] PT_STATUS  = 2'd1;
	localparam logic [1:0] PT_ACTION  = 2'd2;
	localparam logic [1:0] PT_CLOSE   = 2'd3;

	// flag bits of a transmitted packet
	localparam int FLAG_SYN  = 0;
	localparam int FLAG_ACK  = 1;
	localparam int FLAG_TEST = 2;

	// events
	localparam logic [3:0] EV_NONE          = 4'd0;
	localparam logic [3:0] EV_SYN_SENT      = 4'd1;
	localparam logic [3:0] EV_CONNECTED     = 4'd2;
	localparam logic [3:0] EV_ACTION_SENT   = 4'd3;
	localparam logic [3:0] EV_ACKED         = 4'd4;
	localparam logic [3:0] EV_RESENT        = 4'd5;
	localparam logic [3:0] EV_NOT_CONNECTED = 4'd6;
	localparam logic [3:0] EV_BAD_ACK       = 4'd7;
	localparam logic [3:0] EV_GAVE_UP       = 4'd8;
	localparam logic [3:0] EV_PEER_CLOSED   = 4'd9;
	localparam logic [3:0] EV_CLOSED        = 4'd10;
	localparam logic [3:0] EV_BUSY          = 4'd11;
	localparam logic [3:0] EV_STATUS        = 4'd12;
	localparam logic [3:0] EV_BAD_HANDSHAKE = 4'd13;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_HAND = 2'd1,
		MODE_CONN = 2'd2,
		MODE_WAIT = 2'd3
	} mode_t;

	typedef struct packed {
		logic [2:0]                operation;
		logic [7:0]                peer;
		logic                      test_mode;
		logic [7:0]                action_cmd;
		logic [1:0]                pkt_type;
		logic                      pkt_syn;
		logic                      pkt_ack;
		logic                      pkt_nak;
		logic                      pkt_test;
		logic [SEQ_BITS-1:0]       pkt_seq;
		logic [CHALLENGE_BITS-1:0] pkt_challenge;
		logic [7:0]                pkt_backlog;
	} item_t;

	typedef struct packed {
		logic                      send_valid;
		logic [7:0]                send_dest;
		logic [1:0]                send_type;
		logic [2:0]                send_flags;
		logic [SEQ_BITS-1:0]       send_seq;
		logic [CHALLENGE_BITS-1:0] send_challenge;
		logic [7:0]                send_cmd;
		logic [3:0]                event_res;
		logic [1:0]                link_state;
		logic [7:0]                last_backlog;
		logic                      last;
	} res_t;

	// build a result that carries a packet
	function automatic res_t send_pkt(input logic [7:0] dest, input logic [1:0] ptype,
			input logic [2:0] flags, input logic [SEQ_BITS-1:0] seq,
			input logic [CHALLENGE_BITS-1:0] chal, input logic [7:0] cmd,
			input logic [3:0] ev);
		res_t r;
		r                = '0;
		r.send_valid     = 1'b1;
		r.send_dest      = dest;
		r.send_type      = ptype;
		r.send_flags     = flags;
		r.send_seq       = seq;
		r.send_challenge = chal;
		r.send_cmd       = cmd;
		r.event_res      = ev;
		return r;
	endfunction

	// build a result that reports an event only
	function automatic res_t note(input logic [3:0] ev);
		res_t r;
		r           = '0;
		r.event_res = ev;
		return r;
	endfunction

endpackage

>>> design/arlc_core.sv
// Protocol engine of the ack/retry link controller: link state registers and
// the single-pass next-state and result logic for one transaction.
// Depends on arlc_pkg.
module arlc_core
	import arlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  item_t       item,
	input  logic [3:0]  max_attempts,
	input  logic [15:0] ack_timeout_ticks,
	output res_t        res0,
	output res_t        res1,
	output logic        two_res
);

	mode_t               mode_q, n_mode;
	logic [SEQ_BITS-1:0] seq_q, n_seq;
	logic [7:0]          peer_q, n_peer;
	logic [7:0]          pend_q, n_pend;
	logic [3:0]          att_q, n_att;
	logic [15:0]         tmr_q, n_tmr;
	logic [7:0]          backlog_q, n_backlog;

	logic [3:0]          att_inc;
	logic [15:0]         tmr_inc;
	res_t                r0, r1;
	logic                two;
	res_t                close_pkt;

	assign att_inc = att_q + 4'd1;
	assign tmr_inc = tmr_q + 16'd1;

	// CLOSE to the current peer with the current sequence
	assign close_pkt = send_pkt(peer_q, PT_CLOSE, 3'b000, seq_q, '0, 8'd0, EV_NONE);

	// compute next state and results for the held transaction
	always_comb begin
		n_mode    = mode_q;
		n_seq     = seq_q;
		n_peer    = peer_q;
		n_pend    = pend_q;
		n_att     = att_q;
		n_tmr     = tmr_q;
		n_backlog = backlog_q;
		r0        = note(EV_NONE);
		r1        = note(EV_NONE);
		two       = 1'b0;

		case (item.operation)
			OP_OPEN: begin
				if (mode_q != MODE_OFF) begin
					r0 = note(EV_BUSY);
				end else begin
					n_peer = item.peer;
					n_mode = MODE_HAND;
					n_seq  = '0;
					n_att  = '0;
					n_tmr  = '0;
					r0 = send_pkt(item.peer, PT_CONNECT, {item.test_mode, 1'b0, 1'b1},
						'0, '0, 8'd0, EV_SYN_SENT);
				end
			end
			OP_CLOSE: begin
				r0           = close_pkt;
				r0.event_res = EV_CLOSED;
				n_mode       = MODE_OFF;
				n_seq        = '0;
				n_att        = '0;
				n_tmr        = '0;
			end
			OP_ACTION: begin
				if (mode_q == MODE_WAIT) begin
					r0 = note(EV_BUSY);
				end else if (mode_q != MODE_CONN) begin
					r0 = note(EV_NOT_CONNECTED);
				end else if (peer_q == 8'd0) begin
					n_mode = MODE_OFF;
					r0     = note(EV_NOT_CONNECTED);
				end else begin
					n_pend = item.action_cmd;
					n_att  = '0;
					n_tmr  = '0;
					n_mode = MODE_WAIT;
					r0 = send_pkt(peer_q, PT_ACTION, 3'b000, seq_q, '0, item.action_cmd,
						EV_ACTION_SENT);
				end
			end
			OP_PACKET: begin
				case (item.pkt_type)
					PT_CONNECT: begin
						if (mode_q != MODE_HAND) begin
							r0 = note(EV_NONE);
						end else if (!(item.pkt_syn && item.pkt_ack)) begin
							r0 = note(EV_BAD_HANDSHAKE);
						end else begin
							r0 = send_pkt(peer_q, PT_CONNECT, {item.pkt_test, 1'b1, 1'b0},
								'0, ~item.pkt_challenge, 8'd0, EV_CONNECTED);
							n_seq  = SEQ_BITS'(1);
							n_mode = MODE_CONN;
						end
					end
					PT_STATUS: begin
						if (item.pkt_nak) begin
							r0 = note(EV_NONE);
						end else begin
							n_backlog = item.pkt_backlog;
							if (item.pkt_seq == '0 || item.pkt_seq == SEQ_ALL_ONES ||
									mode_q != MODE_WAIT) begin
								r0 = note(EV_STATUS);
							end else if (item.pkt_seq > seq_q) begin
								// ack ahead of us: drop the link
								r0           = close_pkt;
								r0.event_res = EV_BAD_ACK;
								n_mode       = MODE_OFF;
								n_seq        = '0;
								n_att        = '0;
								n_tmr        = '0;
							end else if (item.pkt_seq == seq_q) begin
								n_seq  = seq_q + SEQ_BITS'(1);
								n_mode = MODE_CONN;
								n_att  = '0;
								n_tmr  = '0;
								r0     = note(EV_ACKED);
							end else begin
								// stale ack uses up an attempt
								n_att = att_inc;
								if (att_inc >= max_attempts) begin
									r0           = close_pkt;
									r0.event_res = EV_GAVE_UP;
									n_mode       = MODE_OFF;
									n_seq        = '0;
									n_att        = '0;
									n_tmr        = '0;
								end else begin
									r0 = note(EV_STATUS);
								end
							end
						end
					end
					PT_CLOSE: begin
						n_mode = MODE_OFF;
						n_seq  = '0;
						n_peer = 8'd0;
						n_att  = '0;
						n_tmr  = '0;
						r0     = note(EV_PEER_CLOSED);
					end
					default: begin
						r0 = note(EV_NONE);
					end
				endcase
			end
			OP_TICK: begin
				if (mode_q == MODE_WAIT) begin
					if (tmr_inc >= ack_timeout_ticks) begin
						// timeout: resend, and give up if attempts run out
						n_tmr = '0;
						n_att = att_inc;
						r0 = send_pkt(peer_q, PT_ACTION, 3'b000, seq_q, '0, pend_q, EV_RESENT);
						if (att_inc >= max_attempts) begin
							two          = 1'b1;
							r1           = close_pkt;
							r1.event_res = EV_GAVE_UP;
							n_mode       = MODE_OFF;
							n_seq        = '0;
							n_att        = '0;
						end
					end else begin
						n_tmr = tmr_inc;
						r0    = note(EV_NONE);
					end
				end else begin
					r0 = note(EV_NONE);
				end
			end
			default: begin
				r0 = note(EV_NONE);
			end
		endcase

		// stamp the state after the whole transaction
		r0.link_state   = n_mode;
		r0.last_backlog = n_backlog;
		r0.last         = !two;
		r1.link_state   = n_mode;
		r1.last_backlog = n_backlog;
		r1.last         = 1'b1;
	end

	assign res0    = r0;
	assign res1    = r1;
	assign two_res = two;

	// hold link state, advance on each processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_OFF;
			seq_q     <= '0;
			peer_q    <= 8'd0;
			pend_q    <= 8'd0;
			att_q     <= 4'd0;
			tmr_q     <= 16'd0;
			backlog_q <= 8'd0;
		end else if (fire) begin
			mode_q    <= n_mode;
			seq_q     <= n_seq;
			peer_q    <= n_peer;
			pend_q    <= n_pend;
			att_q     <= n_att;
			tmr_q     <= n_tmr;
			backlog_q <= n_backlog;
		end
	end

`ifndef ASSERT_OFF
	// a double result only comes from a timeout that gives up
	a_two_gave_up: assert property (@(posedge clk) disable iff (!arst_n)
		two |-> (r1.event_res == EV_GAVE_UP && r0.event_res == EV_RESENT))
		else $error("double result without give-up");

	// waiting for an ack always has an owner to send to and a sequence
	a_wait_peer: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && n_mode == MODE_WAIT && mode_q != MODE_WAIT) |-> (peer_q != 8'd0))
		else $error("entered ack wait without peer");

	// a give-up clears the attempts and closes the link
	a_att_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && two) |=> (att_q == 4'd0 && mode_q == MODE_OFF))
		else $error("give-up did not clear the link");
`endif

endmodule

>>> design/arlc_res_fifo.sv
// Result queue of the ack/retry link controller: a small ring of result
// entries that takes one or two results a cycle and hands out one.
// Depends on arlc_pkg.
module arlc_res_fifo
	import arlc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_two,
	input  res_t din0,
	input  res_t din1,
	input  logic pop,
	output res_t dout,
	output logic not_empty,
	output logic room_two
);

	res_t                    mem_q [RES_DEPTH];
	logic [RES_PTR_BITS-1:0] wr_ptr_q;
	logic [RES_PTR_BITS-1:0] rd_ptr_q;
	logic [RES_CNT_BITS-1:0] count_q;
	logic [RES_PTR_BITS-1:0] wr_ptr_nx;
	logic [RES_CNT_BITS-1:0] n_push;
	logic                    do_pop;

	assign wr_ptr_nx = wr_ptr_q + RES_PTR_BITS'(1);
	assign n_push    = push ? (push_two ? RES_CNT_BITS'(2) : RES_CNT_BITS'(1))
		: RES_CNT_BITS'(0);
	assign do_pop    = pop && not_empty;
	assign not_empty = (count_q != '0);
	assign room_two  = (count_q <= RES_CNT_BITS'(RES_DEPTH - 2));
	assign dout      = mem_q[rd_ptr_q];

	// store pushed results
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din0;
			if (push_two) begin
				mem_q[wr_ptr_nx] <= din1;
			end
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_BITS'(n_push);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_BITS'(1);
			end
			count_q <= count_q + n_push - RES_CNT_BITS'(do_pop);
		end
	end

`ifndef ASSERT_OFF
	// never push beyond the free space
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room_two)
		else $error("result queue overflow");

	// fill level stays within the ring
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RES_CNT_BITS'(RES_DEPTH))
		else $error("result queue count out of range");

	// pointer distance matches the fill level
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != RES_CNT_BITS'(RES_DEPTH)) |->
		(RES_PTR_BITS'(wr_ptr_q - rd_ptr_q) == RES_PTR_BITS'(count_q)))
		else $error("result queue pointers disagree with count");
`endif

endmodule

>>> design/ack_retry_link_controller_unit.sv
// Top level of the ack/retry link controller: input register, configuration
// registers, protocol engine and result queue.
// Depends on arlc_pkg, arlc_core and arlc_res_fifo.
//
// Client side of a stop-and-wait link: open/close/action requests, received
// packets and timer ticks enter as items; each item yields one result (two
// when a timeout resend runs out of attempts and the link gives up), the
// final one marked by last. An item is accepted whenever item_stall is low;
// it is held in the input register until the result queue has room for two
// results, is processed in one pass by the protocol engine and is then
// written to a four-entry result queue, whose head drives the result port.
// Sustained rate is one item per cycle while the input does not stall,
// limited by the single result port: a two-result item needs two pops on the
// output side, and the input stalls while the queue lacks room for two
// results.
// Configuration (index 0 max_attempts, index 1 ack_timeout_ticks) is always
// ready and must be written only while the block is idle.
module ack_retry_link_controller_unit
	import arlc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	// item channel
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [2:0]                operation,
	input  logic [7:0]                peer,
	input  logic                      test_mode,
	input  logic [7:0]                action_cmd,
	input  logic [1:0]                pkt_type,
	input  logic                      pkt_syn,
	input  logic                      pkt_ack,
	input  logic                      pkt_nak,
	input  logic                      pkt_test,
	input  logic [SEQ_BITS-1:0]       pkt_seq,
	input  logic [CHALLENGE_BITS-1:0] pkt_challenge,
	input  logic [7:0]                pkt_backlog,
	// result channel
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic                      send_valid,
	output logic [7:0]                send_dest,
	output logic [1:0]                send_type,
	output logic [2:0]                send_flags,
	output logic [SEQ_BITS-1:0]       send_seq,
	output logic [CHALLENGE_BITS-1:0] send_challenge,
	output logic [7:0]                send_cmd,
	output logic [3:0]                event_res,
	output logic [1:0]                link_state,
	output logic [7:0]                last_backlog,
	output logic                      last
);

	logic [3:0]  max_att_q;
	logic [15:0] timeout_q;
	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	logic        accept;
	logic        room_two;
	res_t        res0, res1, head;
	logic        two_res;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && room_two;
	assign item_stall = valid_s1 && !room_two;
	assign accept     = item_valid && !item_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_att_q <= MAX_ATTEMPTS_RST;
			timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_ATTEMPTS: max_att_q <= cfg_data[3:0];
				CFG_ACK_TIMEOUT:  timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture the accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{operation: operation, peer: peer, test_mode: test_mode,
				action_cmd: action_cmd, pkt_type: pkt_type, pkt_syn: pkt_syn,
				pkt_ack: pkt_ack, pkt_nak: pkt_nak, pkt_test: pkt_test,
				pkt_seq: pkt_seq, pkt_challenge: pkt_challenge,
				pkt_backlog: pkt_backlog};
		end
	end

	arlc_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.fire              (advance),
		.item              (item_s1),
		.max_attempts      (max_att_q),
		.ack_timeout_ticks (timeout_q),
		.res0              (res0),
		.res1              (res1),
		.two_res           (two_res)
	);

	arlc_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_two  (two_res),
		.din0      (res0),
		.din1      (res1),
		.pop       (!res_stall),
		.dout      (head),
		.not_empty (res_valid),
		.room_two  (room_two)
	);

	// drive result fields from the queue head
	assign send_valid     = head.send_valid;
	assign send_dest      = head.send_dest;
	assign send_type      = head.send_type;
	assign send_flags     = head.send_flags;
	assign send_seq       = head.send_seq;
	assign send_challenge = head.send_challenge;
	assign send_cmd       = head.send_cmd;
	assign event_res      = head.event_res;
	assign link_state     = head.link_state;
	assign last_backlog   = head.last_backlog;
	assign last           = head.last;

`ifndef ASSERT_OFF
	// stall only while a transaction waits in the input register
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("stall without held transaction");

	// a held transaction that could not advance is still there
	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("held transaction lost");

	// a processed transaction shows up at the result port
	a_result_appears: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid)
		else $error("processed transaction produced no result");
`endif

endmodule
